// File: src/cbm_pkg.sv
// Shared types, codes and constants of the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

   localparam int PICTURE_SLOTS_DEFAULT = 8;
   localparam int PRG_SLOTS = 3;
   localparam int PRG_COUNT_W = 7;

   localparam logic [PRG_COUNT_W-1:0] PRG_BANK_COUNT_RESET = 7'd64;
   localparam logic [14:0] COUNT_MAX = 15'h7FFF;
   localparam logic [3:0] PAGE_BITS_RESET = 4'b1100;

   // Request modes.
   localparam logic [2:0] MODE_BUS_WRITE = 3'd0;
   localparam logic [2:0] MODE_BUS_READ = 3'd1;
   localparam logic [2:0] MODE_TICK = 3'd2;
   localparam logic [2:0] MODE_CPU_XLATE = 3'd3;
   localparam logic [2:0] MODE_PIC_XLATE = 3'd4;

   // Sound port access codes.
   localparam logic [1:0] SND_NONE = 2'd0;
   localparam logic [1:0] SND_DATA_WRITE = 2'd1;
   localparam logic [1:0] SND_DATA_READ = 2'd2;
   localparam logic [1:0] SND_ADDR_WRITE = 2'd3;

   // Mirroring codes.
   localparam logic [1:0] MIRROR_SINGLE_A = 2'd0;
   localparam logic [1:0] MIRROR_SINGLE_B = 2'd1;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd2;
   localparam logic [1:0] MIRROR_VERTICAL = 2'd3;

   // 2 KiB cpu windows, decoded from address bits 15..11.
   localparam logic [4:0] WIN_SOUND_DATA = 5'h09;
   localparam logic [4:0] WIN_COUNT_LO = 5'h0A;
   localparam logic [4:0] WIN_COUNT_HI = 5'h0B;
   localparam logic [4:0] WIN_PICTURE_FIRST = 5'h10;
   localparam logic [4:0] WIN_PICTURE_LAST = 5'h17;
   localparam logic [4:0] WIN_PAGE_FIRST = 5'h18;
   localparam logic [4:0] WIN_PAGE_LAST = 5'h1B;
   localparam logic [4:0] WIN_PRG0 = 5'h1C;
   localparam logic [4:0] WIN_PRG1 = 5'h1D;
   localparam logic [4:0] WIN_PRG2 = 5'h1E;
   localparam logic [4:0] WIN_SOUND_ADDR = 5'h1F;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  cycles;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] bus_rdata;
      logic       read_valid;
      logic       irq_line;
      logic [7:0] bank_number;
      logic       bank_valid;
      logic [1:0] mirror_mode;
      logic       sound_on;
      logic [1:0] sound_access;
   } rsp_payload_type;

   // Bit 0 of pages is the first nametable page.
   function automatic logic [1:0] mirror_decode(input logic [3:0] pages);
      logic [1:0] code;
      if (pages == 4'b0000) begin
         code = MIRROR_SINGLE_A;
      end else if (pages == 4'b1111) begin
         code = MIRROR_SINGLE_B;
      end else if (pages == 4'b1100) begin
         code = MIRROR_HORIZONTAL;
      end else begin
         code = MIRROR_VERTICAL;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// File: src/cbm_if.sv
// Request and response channel interfaces of the cartridge bank mapper.
`default_nettype none

interface cbm_req_if import cbm_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface cbm_rsp_if import cbm_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/cartridge_bank_mapper_with_irq_counter.sv
// Top level of the cartridge bank mapper with its saturating interrupt counter.
// The mapper takes one request per clock while the response side is not stalled, and
// returns one response for each, in order. A request is latched into an input register,
// decoded combinationally against the bank, page, counter and sound registers, and its
// response lands in an output register once that register is empty or being taken.
// The output register lets a new request in while an earlier response waits. The counter
// add and saturation, the write decode and the translation lookups are all combinational
// between the input and output registers. Response flags for irq_line, mirror_mode and
// sound_on show the state after the request has taken effect; reads and translations use
// the state as it stood. The program bank count written through csr_wr_data must only
// change while idle.
`default_nettype none

module cartridge_bank_mapper_with_irq_counter import cbm_pkg::*; #(
   parameter int PICTURE_SLOTS = PICTURE_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   cbm_req_if.sink                req_chan,
   cbm_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [PRG_COUNT_W-1:0] csr_wr_data
);

   localparam int SLOT_BITS = $clog2(PICTURE_SLOTS);

   logic            s1_valid_ff;
   req_payload_type s1_req_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;
   logic            advance;

   logic [7:0]             picture_bank_ff [PICTURE_SLOTS];
   logic [7:0]             picture_bank_in [PICTURE_SLOTS];
   logic [5:0]             program_bank_ff [PRG_SLOTS];
   logic [5:0]             program_bank_in [PRG_SLOTS];
   logic [3:0]             page_bits_ff;
   logic [3:0]             page_bits_in;
   logic [14:0]            tick_count_ff;
   logic [14:0]            tick_count_in;
   logic                   count_enable_ff;
   logic                   count_enable_in;
   logic                   irq_pending_ff;
   logic                   irq_pending_in;
   logic                   sound_enable_ff;
   logic                   sound_enable_in;
   logic [PRG_COUNT_W-1:0] prg_bank_count_ff;

   logic [15:0] tick_sum;
   logic [4:0]  window;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   assign window = s1_req_ff.address[15:11];
   assign tick_sum = {1'b0, tick_count_ff} + {8'b0, s1_req_ff.cycles};

   // Next state of the mapper registers and the response for the request in stage one.
   always_comb begin
      picture_bank_in = picture_bank_ff;
      program_bank_in = program_bank_ff;
      page_bits_in = page_bits_ff;
      tick_count_in = tick_count_ff;
      count_enable_in = count_enable_ff;
      irq_pending_in = irq_pending_ff;
      sound_enable_in = sound_enable_ff;

      rsp_payload_in = '0;

      unique case (s1_req_ff.mode)
         MODE_BUS_WRITE: begin
            case (window) inside
               WIN_SOUND_DATA: begin
                  rsp_payload_in.sound_access = SND_DATA_WRITE;
               end
               WIN_COUNT_LO: begin
                  tick_count_in = {tick_count_ff[14:8], s1_req_ff.data};
                  irq_pending_in = 1'b0;
               end
               WIN_COUNT_HI: begin
                  tick_count_in = {s1_req_ff.data[6:0], tick_count_ff[7:0]};
                  count_enable_in = s1_req_ff.data[7];
                  irq_pending_in = 1'b0;
               end
               [WIN_PICTURE_FIRST:WIN_PICTURE_LAST]: begin
                  picture_bank_in[s1_req_ff.address[11 +: SLOT_BITS]] = s1_req_ff.data;
               end
               [WIN_PAGE_FIRST:WIN_PAGE_LAST]: begin
                  page_bits_in[s1_req_ff.address[12:11]] = s1_req_ff.data[0];
               end
               WIN_PRG0: begin
                  program_bank_in[0] = s1_req_ff.data[5:0];
                  sound_enable_in = !s1_req_ff.data[6];
               end
               WIN_PRG1: begin
                  program_bank_in[1] = s1_req_ff.data[5:0];
               end
               WIN_PRG2: begin
                  program_bank_in[2] = s1_req_ff.data[5:0];
               end
               WIN_SOUND_ADDR: begin
                  rsp_payload_in.sound_access = SND_ADDR_WRITE;
               end
               default: begin
               end
            endcase
         end
         MODE_BUS_READ: begin
            case (window)
               WIN_SOUND_DATA: begin
                  rsp_payload_in.sound_access = SND_DATA_READ;
               end
               WIN_COUNT_LO: begin
                  rsp_payload_in.bus_rdata = tick_count_ff[7:0];
                  rsp_payload_in.read_valid = 1'b1;
               end
               WIN_COUNT_HI: begin
                  rsp_payload_in.bus_rdata = {count_enable_ff, tick_count_ff[14:8]};
                  rsp_payload_in.read_valid = 1'b1;
               end
               default: begin
               end
            endcase
         end
         MODE_TICK: begin
            // The counter stops at its maximum and raises the interrupt on reaching it.
            if (count_enable_ff && (tick_count_ff != COUNT_MAX)) begin
               if (tick_sum >= {1'b0, COUNT_MAX}) begin
                  tick_count_in = COUNT_MAX;
                  irq_pending_in = 1'b1;
               end else begin
                  tick_count_in = tick_sum[14:0];
               end
            end
         end
         MODE_CPU_XLATE: begin
            if (s1_req_ff.address[15] && (prg_bank_count_ff != '0)) begin
               rsp_payload_in.bank_valid = 1'b1;
               case (s1_req_ff.address[14:13])
                  2'd0: rsp_payload_in.bank_number = {2'b0, program_bank_ff[0]};
                  2'd1: rsp_payload_in.bank_number = {2'b0, program_bank_ff[1]};
                  2'd2: rsp_payload_in.bank_number = {2'b0, program_bank_ff[2]};
                  default: begin
                     rsp_payload_in.bank_number =
                        {1'b0, prg_bank_count_ff - PRG_COUNT_W'(1)};
                  end
               endcase
            end
         end
         MODE_PIC_XLATE: begin
            if (s1_req_ff.address[15:13] == 3'b000) begin
               rsp_payload_in.bank_valid = 1'b1;
               rsp_payload_in.bank_number =
                  picture_bank_ff[s1_req_ff.address[10 +: SLOT_BITS]];
            end
         end
         default: begin
         end
      endcase

      rsp_payload_in.irq_line = irq_pending_in;
      rsp_payload_in.mirror_mode = mirror_decode(page_bits_in);
      rsp_payload_in.sound_on = sound_enable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_req_ff <= req_chan.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PICTURE_SLOTS; i++) begin
            picture_bank_ff[i] <= '0;
         end
         for (int i = 0; i < PRG_SLOTS; i++) begin
            program_bank_ff[i] <= '0;
         end
         page_bits_ff <= PAGE_BITS_RESET;
         tick_count_ff <= '0;
         count_enable_ff <= 1'b0;
         irq_pending_ff <= 1'b0;
         sound_enable_ff <= 1'b1;
      end else if (advance) begin
         picture_bank_ff <= picture_bank_in;
         program_bank_ff <= program_bank_in;
         page_bits_ff <= page_bits_in;
         tick_count_ff <= tick_count_in;
         count_enable_ff <= count_enable_in;
         irq_pending_ff <= irq_pending_in;
         sound_enable_ff <= sound_enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bank_count_ff <= PRG_BANK_COUNT_RESET;
      end else if (csr_wr_en) begin
         prg_bank_count_ff <= csr_wr_data;
      end
   end

endmodule

`default_nettype wire

// File: src/cbm_checker.sv
// Port-level checks of the cartridge bank mapper and their binding to the top level.
`default_nettype none

module cbm_checker import cbm_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // A response that is not taken keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Nothing leaves the block in the cycle after a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A sound port access is never also a counter read or a translation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.sound_access != SND_NONE) |->
         !rsp_payload.read_valid && !rsp_payload.bank_valid)
      else $error("sound access mixed with read or translation");

   // With an empty pipeline, a response needs a request accepted before it.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) || $past(rsp_valid)
         || $past(req_valid && req_ready, 3) || !$past(req_ready))
      else $error("response without a request");

endmodule

bind cartridge_bank_mapper_with_irq_counter cbm_checker u_cbm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_payload(rsp_chan.payload)
);

`default_nettype wire
